@@ hw/rtl/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// modexp_pkg
// Widths, register indexes, state codes and the shared modular
// double-and-add step for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // operand width and derived sizes
  localparam int VALUE_WIDTH = 63;
  localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 64;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       bit_cnt_t;

  localparam bit_cnt_t CNT_LAST = bit_cnt_t'(VALUE_WIDTH - 1);

  // register index, taken from paddr[3] (registers at 8-byte spacing)
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REDUCE = 4'b0010,
    ST_MUL    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // one step of (2*r + b*a) mod n, with r, a below n
  // the sum stays below 3n, so at most two subtractions of n apply
  function automatic value_t mod_step(value_t r, value_t a, logic b, value_t n);
    logic [VALUE_WIDTH+1:0] s;
    logic [VALUE_WIDTH+1:0] d1;
    logic [VALUE_WIDTH+1:0] d2;
    s  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : {(VALUE_WIDTH + 2){1'b0}});
    d1 = s - {2'b00, n};
    d2 = s - {1'b0, n, 1'b0};
    priority if (!d2[VALUE_WIDTH+1]) begin
      return d2[VALUE_WIDTH-1:0];
    end else if (!d1[VALUE_WIDTH+1]) begin
      return d1[VALUE_WIDTH-1:0];
    end else begin
      return s[VALUE_WIDTH-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base ^ exponent mod modulus for each input word, using
// right-to-left binary square-and-multiply with bit-serial modular products.
// ----------------------------------------------------------------------------
// One word at a time. An accepted base is first reduced modulo the modulus,
// then for each exponent bit up to the highest set one the multiply and the
// square run side by side, one multiplier bit per cycle, through two
// shift-and-add modular units. A zero exponent or a modulus below two skips
// straight to the finish state. An exponent of zero gives 1; otherwise a
// modulus of zero or one gives 0. The result sits in an output register, so
// the next base is taken while it waits. Modulus (address 0x0) and exponent
// (address 0x8) are written through the APB port; the user must write them
// only while the block is idle, which the block itself does not enforce.
module modular_exponentiation
  import modexp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input stream: tdata = base [VALUE_WIDTH-1:0], zero padding above
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,
  // output stream: tdata = power [VALUE_WIDTH-1:0], zero padding above
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  state_t   state;
  value_t   modulus;
  value_t   exponent;
  value_t   exp_sh;    // exponent bits still to scan
  value_t   b_sh;      // multiplier bits, msb shifted out first
  value_t   acc;       // running result, addend of the multiply unit
  value_t   sq;        // running square, addend of the square unit
  value_t   r_mul;
  value_t   r_sq;
  value_t   r_mul_next;
  value_t   r_sq_next;
  bit_cnt_t cnt;
  logic     out_free;
  logic     wr_en;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= value_t'(2);
      exponent <= value_t'(1);
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_MODULUS:  modulus  <= pwdata[VALUE_WIDTH-1:0];
        REG_EXPONENT: exponent <= pwdata[VALUE_WIDTH-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_MODULUS:  prdata = APB_DATA_W'(modulus);
      REG_EXPONENT: prdata = APB_DATA_W'(exponent);
      default:      prdata = '0;
    endcase
  end

  // bit-serial modular units
  assign r_mul_next = mod_step(r_mul, acc, b_sh[VALUE_WIDTH-1], modulus);
  assign r_sq_next  = mod_step(r_sq, sq, b_sh[VALUE_WIDTH-1], modulus);

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // output register: loaded from finish, emptied when taken
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            // reduce the base as 1 * base mod n on the square unit
            b_sh   <= s_tdata[VALUE_WIDTH-1:0];
            sq     <= value_t'(1);
            r_sq   <= '0;
            cnt    <= CNT_LAST;
            exp_sh <= exponent;
            priority if (exponent == '0) begin
              acc   <= value_t'(1);
              state <= ST_FINISH;
            end else if (modulus < value_t'(2)) begin
              acc   <= '0;
              state <= ST_FINISH;
            end else begin
              acc   <= value_t'(1);
              state <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (cnt == '0) begin
            sq    <= r_sq_next;
            b_sh  <= r_sq_next;
            r_sq  <= '0;
            r_mul <= '0;
            cnt   <= CNT_LAST;
            state <= ST_MUL;
          end else begin
            b_sh <= {b_sh[VALUE_WIDTH-2:0], 1'b0};
            r_sq <= r_sq_next;
            cnt  <= cnt - bit_cnt_t'(1);
          end
        end
        ST_MUL: begin
          if (cnt == '0) begin
            // end of one exponent bit: commit multiply if set, take new square
            if (exp_sh[0]) begin
              acc <= r_mul_next;
            end
            sq     <= r_sq_next;
            b_sh   <= r_sq_next;
            r_sq   <= '0;
            r_mul  <= '0;
            cnt    <= CNT_LAST;
            exp_sh <= exp_sh >> 1;
            if ((exp_sh >> 1) == '0) begin
              state <= ST_FINISH;
            end
          end else begin
            b_sh  <= {b_sh[VALUE_WIDTH-2:0], 1'b0};
            r_sq  <= r_sq_next;
            r_mul <= r_mul_next;
            cnt   <= cnt - bit_cnt_t'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tdata <= TDATA_W'(acc);
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a taken word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != ST_IDLE)
    else $error("accepted word did not leave idle");

  // a finished result is loaded into the output register once it is free
  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_free |=> m_tvalid && state == ST_IDLE)
    else $error("result not delivered from finish");

  // the scan only runs while exponent bits remain
  a_exp_left: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> exp_sh != '0)
    else $error("multiply pass with no exponent bits left");

  // each pass ends by reloading the bit counter
  a_cnt_reload: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE || state == ST_MUL) && cnt == '0 |=>
      cnt == CNT_LAST || state == ST_FINISH)
    else $error("bit counter not reloaded after a pass");
`endif

endmodule

@@ tb/modular_exponentiation_test.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_test
// Self-checking bench for the modular exponentiation block: bases go in on
// the input stream, every power that comes out is compared with a software
// square-and-multiply built on wide products, under a run of modulus and
// exponent settings loaded over the register port and varied idle patterns.
// ----------------------------------------------------------------------------
module modular_exponentiation_test;
  import modexp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_W-1:0] ADDR_MODULUS  = APB_ADDR_W'({REG_MODULUS, 3'b000});
  localparam logic [APB_ADDR_W-1:0] ADDR_EXPONENT = APB_ADDR_W'({REG_EXPONENT, 3'b000});
  localparam value_t VALUE_MAX   = '1;
  localparam int     HOLD_CYCLES = 3000;
  localparam int     DRAIN_WAIT  = 4100;
  localparam int     PHASE_WORDS = 25;

  // wide product reduced by the modulus, operands below the modulus
  function automatic value_t mul_reduce(value_t a, value_t b, value_t n);
    logic [2*VALUE_WIDTH-1:0] prod;
    prod = {{VALUE_WIDTH{1'b0}}, a} * {{VALUE_WIDTH{1'b0}}, b};
    prod = prod % {{VALUE_WIDTH{1'b0}}, n};
    return prod[VALUE_WIDTH-1:0];
  endfunction

  // right-to-left square-and-multiply
  function automatic value_t expected_power(value_t base, value_t n, value_t e);
    value_t acc;
    value_t sq;
    if (e == '0) return value_t'(1);
    if (n < value_t'(2)) return '0;
    acc = value_t'(1);
    sq  = base % n;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      if ((e >> i) == '0) break;
      if (e[i]) acc = mul_reduce(acc, sq, n);
      sq = mul_reduce(sq, sq, n);
    end
    return acc;
  endfunction

  // expected powers in order, with a copy of the register settings
  class power_scoreboard;
    value_t modulus  = value_t'(2);
    value_t exponent = value_t'(1);
    value_t pending[$];
    int     errors   = 0;

    task report(string msg);
      $display("[%0t] error: %s", $realtime, msg);
      errors++;
    endtask

    function void note_base(value_t base);
      pending.push_back(expected_power(base, modulus, exponent));
    endfunction

    task check_power(value_t got);
      value_t want;
      if (pending.size() == 0) begin
        report($sformatf("power %0h with no base outstanding", got));
      end else begin
        want = pending.pop_front();
        if (got !== want) report($sformatf("power %0h, expected %0h", got, want));
      end
    endtask
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  power_scoreboard sb = new();

  int send_idle_pct = 29;
  int recv_idle_pct = 75;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  modular_exponentiation DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #40_000_000;
    $display("modular_exponentiation_test: FAIL");
    $finish;
  end

  // output side: check each word taken, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_power(m_tdata[VALUE_WIDTH-1:0]);
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic value_t rand_value();
    return value_t'({$urandom(), $urandom()});
  endfunction

  // register write: setup cycle then access cycle, bus left selected
  task write_reg(logic [APB_ADDR_W-1:0] addr, value_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {{(APB_DATA_W-VALUE_WIDTH){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task write_config(value_t n, value_t e);
    write_reg(ADDR_MODULUS, n);
    write_reg(ADDR_EXPONENT, e);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.modulus  = n;
    sb.exponent = e;
  endtask

  // offer one base, returns at the edge that takes it
  task send_base(value_t base);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W-VALUE_WIDTH){1'b0}}, base};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_base(base);
  endtask

  // stop offering and wait for every outstanding power
  task drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // bases around the modulus, the extremes and plain random ones
  function automatic value_t pick_base(value_t n);
    case ($urandom_range(9))
      0:       return '0;
      1:       return value_t'(1);
      2:       return n - value_t'(1);
      3:       return n + value_t'($urandom_range(1000));
      4:       return VALUE_MAX;
      5, 6:    return (n == '0) ? rand_value() : rand_value() % n;
      default: return rand_value();
    endcase
  endfunction

  initial begin
    value_t n;
    value_t e;
    int     k;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // settings after reset: modulus two, exponent one
    send_base('0);
    send_base(value_t'(3));
    send_base(VALUE_MAX);
    drain();

    // exponent zero gives one, even for modulus zero
    write_config(VALUE_MAX, '0);
    send_base('0);
    send_base(VALUE_MAX);
    drain();
    write_config('0, '0);
    send_base(value_t'(5));
    drain();

    // modulus one and modulus zero give zero
    write_config(value_t'(1), value_t'(5));
    send_base(VALUE_MAX);
    send_base(value_t'(2));
    drain();
    write_config('0, value_t'(3));
    send_base(value_t'(7));
    send_base(VALUE_MAX);
    drain();

    // full-width modulus and exponent, base at and just below the modulus
    write_config(VALUE_MAX, VALUE_MAX);
    send_base(VALUE_MAX - value_t'(1));
    send_base(VALUE_MAX);
    send_base(value_t'(1) << (VALUE_WIDTH - 1));
    drain();
    write_config(value_t'(2), VALUE_MAX);
    send_base(value_t'(3));
    drain();

    // small key pair: encrypt then decrypt
    write_config(value_t'(3233), value_t'(17));
    send_base(value_t'(65));
    send_base(value_t'(3233 + 65));
    drain();
    write_config(value_t'(3233), value_t'(2753));
    send_base(value_t'(2790));
    send_base(value_t'(3232));
    drain();

    // random settings under three idle patterns
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 29; recv_idle_pct = 75; end
        1:       begin send_idle_pct = 75; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        case (ph)
          0:       n = value_t'($urandom_range(1000, 2));
          1:       n = value_t'($urandom);
          default: n = rand_value();
        endcase
        if (ph == 0 && $urandom_range(3) == 0) n = value_t'($urandom_range(1));
        if (ph == 3) begin
          e = rand_value() | (value_t'(1) << (VALUE_WIDTH - 1));
        end else begin
          k = $urandom_range(16, 1);
          e = rand_value() & ((value_t'(1) << k) - value_t'(1));
        end
        write_config(n, e);
        for (int w = 0; w < PHASE_WORDS; w++) begin
          // long output stall while bases keep coming
          if (mode == 2 && ph == 0 && w == 4) hold_req++;
          // pause input until the block has emptied
          if (ph == 1 && w == 12) drain();
          send_base(pick_base(n));
        end
        drain();
      end
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("powers still outstanding at end");
    if (sb.errors == 0) begin
      $display("modular_exponentiation_test: PASS");
    end else begin
      $display("modular_exponentiation_test: FAIL");
    end
    $finish;
  end

endmodule
